// File: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, sizes and codes for the min-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int DEPTH   = 8;
  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 3;
  localparam int FILL_W  = 4;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NXT_W   = CNT_W + 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // request operations
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // which result the datapath registers this cycle
  localparam int FIN_W = 3;
  localparam logic [FIN_W-1:0] FIN_NONE  = 3'd0;
  localparam logic [FIN_W-1:0] FIN_PUSH  = 3'd1;
  localparam logic [FIN_W-1:0] FIN_POP   = 3'd2;
  localparam logic [FIN_W-1:0] FIN_LOW   = 3'd3;
  localparam logic [FIN_W-1:0] FIN_EMPTY = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] result_value;
    logic [IDX_W-1:0]         result_index;
    logic [FILL_W-1:0]        fill;
  } rsp_t;

  typedef struct packed {
    logic             push;
    logic             top_read;
    logic             scan_start;
    logic             scan_step;
    logic             shift_start;
    logic             shift_step;
    logic             remove;
    logic [FIN_W-1:0] finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
    logic shift_none;
    logic shift_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for the min-tracking stack: decodes a request and steps the
// datapath through top read, lowest-value scan and shift-down.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [mts_pkg::OP_W-1:0] op,
  input  wire mts_pkg::dp_stat_t        stat,
  output mts_pkg::cmd_t                 cmd,
  output logic                          busy
);
  import mts_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POP      = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SH_PRIME = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_FIN      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       remove;
  logic       remove_next;

  always_comb begin
    cmd         = '0;
    cmd.finish  = FIN_NONE;
    state_next  = state;
    remove_next = remove;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_PUSH: begin
              cmd.push   = 1'b1;
              cmd.finish = FIN_PUSH;
            end
            OP_POP: begin
              if (stat.empty) begin
                cmd.finish = FIN_EMPTY;
              end else begin
                cmd.top_read = 1'b1;
                state_next   = S_POP;
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.finish = FIN_EMPTY;
              end else begin
                cmd.scan_start = 1'b1;
                remove_next    = (op == OP_REMOVE);
                state_next     = S_SCAN;
              end
            end
          endcase
        end
      end
      S_POP: begin
        cmd.finish = FIN_POP;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = remove ? S_SH_PRIME : S_FIN;
        end
      end
      S_SH_PRIME: begin
        cmd.shift_start = 1'b1;
        state_next      = stat.shift_none ? S_FIN : S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = FIN_LOW;
        cmd.remove = remove;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      remove <= 1'b0;
    end else begin
      state  <= state_next;
      remove <= remove_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath for the min-tracking stack: entry memory, fill count, scan and
// shift pointers, running lowest value and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mts_pkg::req_t req,
  input  wire mts_pkg::cmd_t cmd,
  output mts_pkg::dp_stat_t  stat,
  output mts_pkg::rsp_t      result,
  output logic               done
);
  import mts_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic signed [WORD_W-1:0] best_val;
  logic [ADDR_W-1:0]        best_idx;
  logic [ADDR_W-1:0]        sh_ptr;
  logic [CNT_W-1:0]         rd_idx;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [WORD_W-1:0] wr_data;

  logic [CNT_W-1:0]         cnt_dec;
  logic [NXT_W-1:0]         cnt_ext;
  logic [NXT_W-1:0]         rd_inc;
  logic [NXT_W-1:0]         best_inc;
  logic [NXT_W-1:0]         sh_inc2;
  logic                     best_take;
  rsp_t                     rsp_next;

  assign cnt_dec  = count - CNT_W'(1);
  assign cnt_ext  = NXT_W'(count);
  assign rd_inc   = NXT_W'(rd_idx) + NXT_W'(1);
  assign best_inc = NXT_W'(best_idx) + NXT_W'(1);
  assign sh_inc2  = NXT_W'(sh_ptr) + NXT_W'(2);

  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CNT_W'(DEPTH));
  assign stat.scan_last  = (rd_inc >= cnt_ext);
  assign stat.shift_none = (best_inc >= cnt_ext);
  assign stat.shift_last = (sh_inc2 >= cnt_ext);

  assign best_take = (rd_idx == '0) || (rdata < best_val);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = sh_ptr;
    wr_data = rdata;
    if (cmd.push && !stat.full) begin
      wr_en   = 1'b1;
      wr_addr = count[ADDR_W-1:0];
      wr_data = req.value;
    end
    if (cmd.top_read) begin
      rd_en   = 1'b1;
      rd_addr = cnt_dec[ADDR_W-1:0];
    end
    if (cmd.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd.scan_step && !stat.scan_last) begin
      rd_en   = 1'b1;
      rd_addr = rd_inc[ADDR_W-1:0];
    end
    if (cmd.shift_start && !stat.shift_none) begin
      rd_en   = 1'b1;
      rd_addr = best_inc[ADDR_W-1:0];
    end
    if (cmd.shift_step) begin
      // move the entry read last cycle down one place
      wr_en   = 1'b1;
      wr_addr = sh_ptr;
      wr_data = rdata;
      if (!stat.shift_last) begin
        rd_en   = 1'b1;
        rd_addr = sh_inc2[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // result and fill count
  always_comb begin
    count_next = count;
    rsp_next   = '0;
    case (cmd.finish)
      FIN_PUSH: begin
        if (stat.full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status = ST_OK;
          count_next      = count + CNT_W'(1);
        end
      end
      FIN_POP: begin
        rsp_next.status       = ST_OK;
        rsp_next.result_value = rdata;
        count_next            = cnt_dec;
      end
      FIN_LOW: begin
        rsp_next.status       = ST_OK;
        rsp_next.result_value = best_val;
        rsp_next.result_index = IDX_W'(best_idx);
        if (cmd.remove) begin
          count_next = cnt_dec;
        end
      end
      FIN_EMPTY: begin
        rsp_next.status = ST_EMPTY;
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.fill = FILL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= (cmd.finish != FIN_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish != FIN_NONE) begin
      result <= rsp_next;
    end
    if (cmd.scan_start) begin
      rd_idx <= '0;
    end else if (cmd.scan_step) begin
      rd_idx <= rd_inc[CNT_W-1:0];
      if (best_take) begin
        best_val <= rdata;
        best_idx <= rd_idx[ADDR_W-1:0];
      end
    end
    if (cmd.shift_start) begin
      sh_ptr <= best_idx;
    end else if (cmd.shift_step) begin
      sh_ptr <= sh_ptr + ADDR_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish == FIN_POP) |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not drop the fill count");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !stat.full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not raise the fill count");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (rd_idx < count))
    else $error("scan past the top of the stack");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> (sh_inc2 <= cnt_ext))
    else $error("shift past the top of the stack");
`endif

endmodule

`default_nettype wire

// File: rtl/min_tracking_stack.sv
// Push and requests on an empty stack: result strobe in the cycle after acceptance.
// Pop: one memory read of the top entry.
// Find-lowest: the scan reads one entry per cycle on the single read port.
// Remove-lowest: scan, then one shifted entry per cycle.
// busy drops as the strobe rises, so a new request is taken in the strobe cycle.
// Synchronous reset empties the stack; entry contents are not cleared.
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed words with find-lowest and remove-lowest requests.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire mts_pkg::req_t req,
  output logic               done,
  output mts_pkg::rsp_t      result
);
  import mts_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (req.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mts_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

endmodule

`default_nettype wire
